// ===== rtl/assert_macros.svh =====
// assertion helpers used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define AWS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled while in reset
`define AWS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/aws_pkg.sv =====
// ----------------------------------------------------------------------------
// aws_pkg
// Shared widths, codes and stage records of the affine warp sampler.
// ----------------------------------------------------------------------------
package aws_pkg;

  // fixed field widths
  localparam int VALUE_W = 16;
  localparam int OCOL_W  = 12;
  localparam int LCOL_W  = 8;
  localparam int LVAL_W  = 16;
  localparam int DIM_W   = 9;
  localparam int START_W = 25;
  localparam int STEP_W  = 24;
  localparam int CFG_W   = 25;
  localparam int FRAC_W  = 16;
  localparam int PROD_W  = 37;
  localparam int CORD_W  = 39;
  localparam int IX_W    = CORD_W - FRAC_W;
  localparam int WT_W    = FRAC_W + 1;

  // q16 constants
  localparam logic [WT_W-1:0]   ONE_Q16  = WT_W'(65536);
  localparam logic [CORD_W-1:0] HALF_Q16 = CORD_W'(32768);

  // parameter defaults
  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_HEIGHT = 256;
  localparam int DEF_PIXEL_BITS = 16;
  localparam int DEF_SNAP_TOL   = 16;

  typedef enum logic [1:0] {
    REQ_LOAD     = 2'd0,
    REQ_NEAREST  = 2'd1,
    REQ_BILINEAR = 2'd2
  } req_t;

  typedef enum logic [2:0] {
    CFG_IN_WIDTH  = 3'd0,
    CFG_IN_HEIGHT = 3'd1,
    CFG_START_X   = 3'd2,
    CFG_START_Y   = 3'd3,
    CFG_STEP_XX   = 3'd4,
    CFG_STEP_XY   = 3'd5,
    CFG_STEP_YX   = 3'd6,
    CFG_STEP_YY   = 3'd7
  } cfg_idx_t;

  // transform settings, dimensions already clamped
  typedef struct packed {
    logic        [DIM_W-1:0]   w_eff;
    logic        [DIM_W-1:0]   h_eff;
    logic signed [START_W-1:0] start_x;
    logic signed [START_W-1:0] start_y;
    logic signed [STEP_W-1:0]  step_xx;
    logic signed [STEP_W-1:0]  step_xy;
    logic signed [STEP_W-1:0]  step_yx;
    logic signed [STEP_W-1:0]  step_yy;
  } cfg_t;

  // item after the coordinate stages
  typedef struct packed {
    logic                     valid;
    logic [1:0]               req;
    logic                     load_ok;
    logic [LCOL_W-1:0]        lcol;
    logic [LCOL_W-1:0]        lrow;
    logic [LVAL_W-1:0]        lval;
    logic signed [CORD_W-1:0] x;
    logic signed [CORD_W-1:0] y;
    logic [OCOL_W-1:0]        col;
    logic [OCOL_W-1:0]        row;
  } coord_t;

  // one axis after floor, snap and range test
  typedef struct packed {
    logic                   ok;
    logic signed [IX_W-1:0] idx;
    logic [WT_W-1:0]        frac;
  } axis_t;

  // sample item alongside the pixel reads
  typedef struct packed {
    logic              valid;
    logic              pt_ok;
    logic [WT_W-1:0]   fx;
    logic [WT_W-1:0]   fy;
    logic              xp;
    logic              yp;
    logic [OCOL_W-1:0] col;
    logic [OCOL_W-1:0] row;
  } meta_t;

endpackage

// ===== rtl/aws_ram.sv =====
// ----------------------------------------------------------------------------
// aws_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module aws_ram #(
  parameter int DATA_W = 16,
  parameter int DEPTH  = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [DATA_W-1:0]        wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [DATA_W-1:0]        rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/aws_coord.sv =====
// ----------------------------------------------------------------------------
// aws_coord
// Two stages: coordinate products, then the sums giving source x and y.
// ----------------------------------------------------------------------------
module aws_coord import aws_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic [1:0]        req,
  input  logic [LCOL_W-1:0] lcol,
  input  logic [LCOL_W-1:0] lrow,
  input  logic [LVAL_W-1:0] lval,
  input  logic [OCOL_W-1:0] col,
  input  logic [OCOL_W-1:0] row,
  input  cfg_t              cfg,
  output coord_t            coord
);

  // stage 1 registers
  logic                     v1_r;
  logic [1:0]               req1_r;
  logic                     load_ok1_r;
  logic [LCOL_W-1:0]        lcol1_r, lrow1_r;
  logic [LVAL_W-1:0]        lval1_r;
  logic [OCOL_W-1:0]        col1_r, row1_r;
  logic signed [PROD_W-1:0] pxx_r, pxy_r, pyx_r, pyy_r;
  logic signed [PROD_W-1:0] pxx_nxt, pxy_nxt, pyx_nxt, pyy_nxt;
  logic signed [OCOL_W:0]   col_s, row_s;
  logic                     load_ok_nxt;

  // stage 2 registers
  coord_t                   coord_r, coord_nxt;

  // column and row as signed operands
  assign col_s = $signed({1'b0, col});
  assign row_s = $signed({1'b0, row});

  // four products and the load range check
  always_comb begin
    pxx_nxt     = col_s * cfg.step_xx;
    pxy_nxt     = row_s * cfg.step_xy;
    pyx_nxt     = col_s * cfg.step_yx;
    pyy_nxt     = row_s * cfg.step_yy;
    load_ok_nxt = (32'(lcol) < MAX_WIDTH) && (32'(lrow) < MAX_HEIGHT);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    req1_r     <= req;
    load_ok1_r <= load_ok_nxt;
    lcol1_r    <= lcol;
    lrow1_r    <= lrow;
    lval1_r    <= lval;
    col1_r     <= col;
    row1_r     <= row;
    pxx_r      <= pxx_nxt;
    pxy_r      <= pxy_nxt;
    pyx_r      <= pyx_nxt;
    pyy_r      <= pyy_nxt;
  end

  // sums, with the half offset for nearest rounding
  always_comb begin
    logic [CORD_W-1:0] half;
    half                = (req1_r == REQ_NEAREST) ? HALF_Q16 : '0;
    coord_nxt.valid     = v1_r;
    coord_nxt.req       = req1_r;
    coord_nxt.load_ok   = load_ok1_r;
    coord_nxt.lcol      = lcol1_r;
    coord_nxt.lrow      = lrow1_r;
    coord_nxt.lval      = lval1_r;
    coord_nxt.col       = col1_r;
    coord_nxt.row       = row1_r;
    coord_nxt.x         = CORD_W'(cfg.start_x) + CORD_W'(pxx_r) + CORD_W'(pxy_r) + half;
    coord_nxt.y         = CORD_W'(cfg.start_y) + CORD_W'(pyx_r) + CORD_W'(pyy_r) + half;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coord_r.valid <= 1'b0;
    end else begin
      coord_r.valid <= coord_nxt.valid;
    end
  end

  always_ff @(posedge clk) begin
    coord_r.req     <= coord_nxt.req;
    coord_r.load_ok <= coord_nxt.load_ok;
    coord_r.lcol    <= coord_nxt.lcol;
    coord_r.lrow    <= coord_nxt.lrow;
    coord_r.lval    <= coord_nxt.lval;
    coord_r.x       <= coord_nxt.x;
    coord_r.y       <= coord_nxt.y;
    coord_r.col     <= coord_nxt.col;
    coord_r.row     <= coord_nxt.row;
  end

  assign coord = coord_r;

endmodule

// ===== rtl/aws_fetch.sv =====
// ----------------------------------------------------------------------------
// aws_fetch
// Floor, edge snap and range test, then reads of the four pixel banks.
// Banks split the image by column and row parity, so the four neighbors
// of a point always sit in four different banks.
// ----------------------------------------------------------------------------
module aws_fetch import aws_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int PIXEL_BITS = DEF_PIXEL_BITS,
  parameter int SNAP_TOL   = DEF_SNAP_TOL
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  coord_t                    coord,
  input  logic [DIM_W-1:0]          w_eff,
  input  logic [DIM_W-1:0]          h_eff,
  output meta_t                     meta,
  output logic [3:0][PIXEL_BITS-1:0] pix
);

  localparam int CW  = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
  localparam int RW  = (MAX_HEIGHT > 2) ? $clog2(MAX_HEIGHT) : 1;
  localparam int CAW = (CW > 1) ? CW - 1 : 1;
  localparam int RAW = (RW > 1) ? RW - 1 : 1;
  localparam int BAW = CAW + RAW;
  localparam logic [WT_W-1:0] TOL = WT_W'(SNAP_TOL);

  // floor, snap and range test of one axis
  function automatic axis_t axis_map(input logic signed [CORD_W-1:0] c,
                                     input logic [DIM_W-1:0] dim,
                                     input logic near);
    logic signed [IX_W-1:0] xi, xe, d, dm1, dm2;
    logic [WT_W-1:0]        f, fe;
    axis_t                  a;
    xi  = c[CORD_W-1:FRAC_W];
    f   = {1'b0, c[FRAC_W-1:0]};
    d   = $signed(IX_W'(dim));
    dm1 = d - IX_W'(1);
    dm2 = d - IX_W'(2);
    xe  = xi;
    fe  = f;
    if (near) begin
      fe   = '0;
      a.ok = (xi >= 0) && (xi < d);
    end else begin
      // a point just outside the near edge or on the far edge snaps inward
      if ((xi == -1) && ((ONE_Q16 - f) < TOL)) begin
        xe = '0;
        fe = '0;
      end else if ((xi == dm1) && (f < TOL)) begin
        xe = dm2;
        fe = ONE_Q16;
      end
      a.ok = (xe >= 0) && (xe < dm1);
    end
    a.idx  = xe;
    a.frac = fe;
    return a;
  endfunction

  axis_t             ax, ay;
  logic              near, is_sample, is_load;
  logic [CW-1:0]     col0, col1, lc;
  logic [RW-1:0]     row0, row1, lr;
  logic [BAW-1:0]    wr_addr;
  logic [1:0]        wr_bank;
  logic [PIXEL_BITS-1:0] wr_data;
  meta_t             meta_r, meta_nxt;

  assign near      = (coord.req == REQ_NEAREST);
  assign is_sample = coord.valid && ((coord.req == REQ_NEAREST) ||
                                     (coord.req == REQ_BILINEAR));
  assign is_load   = coord.valid && (coord.req == REQ_LOAD) && coord.load_ok;

  assign ax = axis_map(coord.x, w_eff, near);
  assign ay = axis_map(coord.y, h_eff, near);

  // neighbor columns and rows
  assign col0 = ax.idx[CW-1:0];
  assign col1 = col0 + 1'b1;
  assign row0 = ay.idx[RW-1:0];
  assign row1 = row0 + 1'b1;

  // load write address
  assign lc      = CW'(coord.lcol);
  assign lr      = RW'(coord.lrow);
  assign wr_bank = {lr[0], lc[0]};
  assign wr_addr = {RAW'(lr >> 1), CAW'(lc >> 1)};
  assign wr_data = PIXEL_BITS'(coord.lval);

  // one bank for each column and row parity
  for (genvar b = 0; b < 4; b++) begin : g_bank
    localparam logic CP = (b % 2) == 1;
    localparam logic RP = (b / 2) == 1;
    logic [CW-1:0]  colsel;
    logic [RW-1:0]  rowsel;
    logic [BAW-1:0] rd_addr;

    assign colsel  = (col0[0] == CP) ? col0 : col1;
    assign rowsel  = (row0[0] == RP) ? row0 : row1;
    assign rd_addr = {RAW'(rowsel >> 1), CAW'(colsel >> 1)};

    aws_ram #(
      .DATA_W (PIXEL_BITS),
      .DEPTH  (2 ** BAW)
    ) u_ram (
      .clk     (clk),
      .wr_en   (is_load && (wr_bank == 2'(b))),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (is_sample),
      .rd_addr (rd_addr),
      .rd_data (pix[b])
    );
  end

  // item record aligned with the read data
  always_comb begin
    meta_nxt.valid = is_sample;
    meta_nxt.pt_ok = ax.ok && ay.ok;
    meta_nxt.fx    = ax.frac;
    meta_nxt.fy    = ay.frac;
    meta_nxt.xp    = col0[0];
    meta_nxt.yp    = row0[0];
    meta_nxt.col   = coord.col;
    meta_nxt.row   = coord.row;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      meta_r.valid <= 1'b0;
    end else begin
      meta_r.valid <= meta_nxt.valid;
    end
  end

  always_ff @(posedge clk) begin
    meta_r.pt_ok <= meta_nxt.pt_ok;
    meta_r.fx    <= meta_nxt.fx;
    meta_r.fy    <= meta_nxt.fy;
    meta_r.xp    <= meta_nxt.xp;
    meta_r.yp    <= meta_nxt.yp;
    meta_r.col   <= meta_nxt.col;
    meta_r.row   <= meta_nxt.row;
  end

  assign meta = meta_r;

endmodule

// ===== rtl/aws_blend.sv =====
// ----------------------------------------------------------------------------
// aws_blend
// Horizontal blend of both row pairs, then vertical blend and rounding.
// Nearest items come through with zero weights, giving the top-left pixel.
// ----------------------------------------------------------------------------
module aws_blend import aws_pkg::*; #(
  parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  meta_t                      meta,
  input  logic [3:0][PIXEL_BITS-1:0] pix,
  output logic                       strobe,
  output logic [VALUE_W-1:0]         value,
  output logic                       valid,
  output logic [OCOL_W-1:0]          res_col,
  output logic [OCOL_W-1:0]          res_row
);

  localparam int PB = PIXEL_BITS;
  localparam int HW = PB + FRAC_W;
  localparam int TW = PB + WT_W + 2;
  localparam int VW = HW + FRAC_W;
  localparam int SW = HW + WT_W + 2;
  localparam logic [VW-1:0] RND = VW'(64'h8000_0000);

  logic [PB-1:0]     p00, p01, p10, p11;
  logic [HW-1:0]     top_nxt, bot_nxt, top_r, bot_r;
  logic              v4_r, ok4_r;
  logic [WT_W-1:0]   fy4_r;
  logic [OCOL_W-1:0] col4_r, row4_r;
  logic [VALUE_W-1:0] value_nxt;
  logic              strobe_r, valid_r;
  logic [VALUE_W-1:0] value_r;
  logic [OCOL_W-1:0] col5_r, row5_r;

  // pick the four neighbors by parity
  assign p00 = pix[{meta.yp, meta.xp}];
  assign p01 = pix[{meta.yp, ~meta.xp}];
  assign p10 = pix[{~meta.yp, meta.xp}];
  assign p11 = pix[{~meta.yp, ~meta.xp}];

  // horizontal blend: p*(1-f) + q*f = p*one + (q-p)*f
  // a zero weight ignores the right column, which a nearest item never loaded
  always_comb begin
    logic signed [TW-1:0] dt, db, fx_s, pt, pb_;
    dt      = (meta.fx == '0) ? '0 : ($signed(TW'(p01)) - $signed(TW'(p00)));
    db      = (meta.fx == '0) ? '0 : ($signed(TW'(p11)) - $signed(TW'(p10)));
    fx_s    = $signed(TW'(meta.fx));
    pt      = $signed(TW'({p00, FRAC_W'(0)})) + dt * fx_s;
    pb_     = $signed(TW'({p10, FRAC_W'(0)})) + db * fx_s;
    top_nxt = HW'(pt);
    bot_nxt = HW'(pb_);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else begin
      v4_r <= meta.valid;
    end
  end

  always_ff @(posedge clk) begin
    top_r  <= top_nxt;
    bot_r  <= bot_nxt;
    ok4_r  <= meta.pt_ok;
    fy4_r  <= meta.fy;
    col4_r <= meta.col;
    row4_r <= meta.row;
  end

  // vertical blend and round to nearest, half up
  // a zero weight ignores the bottom row
  always_comb begin
    logic signed [SW-1:0] dv, fy_s, s;
    logic [VW-1:0]        su;
    dv        = (fy4_r == '0) ? '0 : ($signed(SW'(bot_r)) - $signed(SW'(top_r)));
    fy_s      = $signed(SW'(fy4_r));
    s         = $signed(SW'({top_r, FRAC_W'(0)})) + dv * fy_s;
    su        = VW'(s) + RND;
    value_nxt = ok4_r ? VALUE_W'(su[VW-1:2*FRAC_W]) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
    valid_r <= ok4_r;
    col5_r  <= col4_r;
    row5_r  <= row4_r;
  end

  assign strobe  = strobe_r;
  assign value   = value_r;
  assign valid   = valid_r;
  assign res_col = col5_r;
  assign res_row = row5_r;

endmodule

// ===== rtl/affine_warp_sampler_top.sv =====
// ----------------------------------------------------------------------------
// affine_warp_sampler_top
// Affine image warp with nearest and bilinear sampling from a loaded image.
// ----------------------------------------------------------------------------
// Usage:
//   input items: start with in_req_type and fields; taken when start is high
//   and busy is low. busy stays low, so an item may be taken every cycle.
//   load items write one pixel and give no result; sample items give one
//   result, unused request codes give none.
//   results: out_strobe high for one cycle with value, valid flag and the
//   echoed column and row; the receiver cannot stall, nothing is held.
//   pipeline: a sample result passes the registered stages for products,
//   sums, snap and bank read, horizontal blend and vertical blend.
//   throughput: 1 item per cycle; four parity banks serve all four
//   neighbors of a bilinear point in one read.
//   loads and samples stay in order: a load writes its bank in the same
//   stage where samples read, so later samples see it and earlier ones not.
//   configuration: cfg_we, cfg_addr, cfg_wdata, to be written only while idle; the block does not enforce it.
//   reset: synchronous rst_n clears the pipeline and sets the registers to
//   their defaults; image contents are undefined until loaded.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module affine_warp_sampler_top import aws_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int PIXEL_BITS = DEF_PIXEL_BITS,
  parameter int SNAP_TOL   = DEF_SNAP_TOL
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_req_type,
  input  logic [LCOL_W-1:0]  in_load_col,
  input  logic [LCOL_W-1:0]  in_load_row,
  input  logic [LVAL_W-1:0]  in_load_value,
  input  logic [OCOL_W-1:0]  in_out_col,
  input  logic [OCOL_W-1:0]  in_out_row,
  output logic               out_strobe,
  output logic [VALUE_W-1:0] out_sample_value,
  output logic               out_sample_valid,
  output logic [OCOL_W-1:0]  out_res_col,
  output logic [OCOL_W-1:0]  out_res_row,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_addr,
  input  logic [CFG_W-1:0]   cfg_wdata
);

  logic [DIM_W-1:0]          in_width_r, in_height_r;
  logic signed [START_W-1:0] start_x_r, start_y_r;
  logic signed [STEP_W-1:0]  step_xx_r, step_xy_r, step_yx_r, step_yy_r;
  cfg_t                      cfg;
  coord_t                    coord;
  meta_t                     meta;
  logic [3:0][PIXEL_BITS-1:0] pix;
  logic                      accept, is_sample;

  assign busy      = 1'b0;
  assign accept    = start && !busy;
  assign is_sample = (in_req_type == REQ_NEAREST) || (in_req_type == REQ_BILINEAR);

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_width_r  <= DIM_W'(256);
      in_height_r <= DIM_W'(256);
      start_x_r   <= '0;
      start_y_r   <= '0;
      step_xx_r   <= STEP_W'(65536);
      step_xy_r   <= '0;
      step_yx_r   <= '0;
      step_yy_r   <= STEP_W'(65536);
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_addr))
        CFG_IN_WIDTH:  in_width_r  <= cfg_wdata[DIM_W-1:0];
        CFG_IN_HEIGHT: in_height_r <= cfg_wdata[DIM_W-1:0];
        CFG_START_X:   start_x_r   <= cfg_wdata[START_W-1:0];
        CFG_START_Y:   start_y_r   <= cfg_wdata[START_W-1:0];
        CFG_STEP_XX:   step_xx_r   <= cfg_wdata[STEP_W-1:0];
        CFG_STEP_XY:   step_xy_r   <= cfg_wdata[STEP_W-1:0];
        CFG_STEP_YX:   step_yx_r   <= cfg_wdata[STEP_W-1:0];
        CFG_STEP_YY:   step_yy_r   <= cfg_wdata[STEP_W-1:0];
      endcase
    end
  end

  // clamp dimensions to the store size
  always_comb begin
    cfg.w_eff   = (32'(in_width_r) > MAX_WIDTH) ? DIM_W'(MAX_WIDTH) : in_width_r;
    cfg.h_eff   = (32'(in_height_r) > MAX_HEIGHT) ? DIM_W'(MAX_HEIGHT) : in_height_r;
    cfg.start_x = start_x_r;
    cfg.start_y = start_y_r;
    cfg.step_xx = step_xx_r;
    cfg.step_xy = step_xy_r;
    cfg.step_yx = step_yx_r;
    cfg.step_yy = step_yy_r;
  end

  aws_coord #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_coord (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .req    (in_req_type),
    .lcol   (in_load_col),
    .lrow   (in_load_row),
    .lval   (in_load_value),
    .col    (in_out_col),
    .row    (in_out_row),
    .cfg    (cfg),
    .coord  (coord)
  );

  aws_fetch #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .PIXEL_BITS (PIXEL_BITS),
    .SNAP_TOL   (SNAP_TOL)
  ) u_fetch (
    .clk   (clk),
    .rst_n (rst_n),
    .coord (coord),
    .w_eff (cfg.w_eff),
    .h_eff (cfg.h_eff),
    .meta  (meta),
    .pix   (pix)
  );

  aws_blend #(
    .PIXEL_BITS (PIXEL_BITS)
  ) u_blend (
    .clk     (clk),
    .rst_n   (rst_n),
    .meta    (meta),
    .pix     (pix),
    .strobe  (out_strobe),
    .value   (out_sample_value),
    .valid   (out_sample_valid),
    .res_col (out_res_col),
    .res_row (out_res_row)
  );

  // every sample item comes out as a result strobe
  `AWS_ASSERT_IMP(a_sample_out, clk, rst_n, accept && is_sample, ##5 out_strobe, "sample item lost")
  // loads and unused codes give no result
  `AWS_ASSERT_NXT(a_load_quiet, clk, rst_n, accept && !is_sample, ##4 !out_strobe, "result without sample")
  // echoed position matches the item that the result belongs to
  `AWS_ASSERT_IMP(a_echo, clk, rst_n, out_strobe, (out_res_col == $past(in_out_col, 5)) && (out_res_row == $past(in_out_row, 5)), "echo mismatch")
  // a point outside the source reads as zero
  `AWS_ASSERT_IMP(a_zero_invalid, clk, rst_n, out_strobe && !out_sample_valid, out_sample_value == '0, "invalid sample not zero")

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the affine warp sampler: loads source pixels,
// programs the transform registers and checks nearest and bilinear samples
// against a predictor that tracks the image and registers independently.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
  import aws_pkg::*;

  localparam int STORE_W   = 256;
  localparam int STORE_H   = 256;
  localparam int EDGE_TOL  = 16;
  localparam int DRAIN_CYC = 10;

  typedef struct {
    logic [VALUE_W-1:0] value;
    logic               ok;
    logic [OCOL_W-1:0]  col;
    logic [OCOL_W-1:0]  row;
  } sample_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] in_req_type = '0;
  logic [LCOL_W-1:0] in_load_col = '0;
  logic [LCOL_W-1:0] in_load_row = '0;
  logic [LVAL_W-1:0] in_load_value = '0;
  logic [OCOL_W-1:0] in_out_col = '0;
  logic [OCOL_W-1:0] in_out_row = '0;
  logic out_strobe;
  logic [VALUE_W-1:0] out_sample_value;
  logic out_sample_valid;
  logic [OCOL_W-1:0] out_res_col;
  logic [OCOL_W-1:0] out_res_row;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_addr = '0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  affine_warp_sampler_top dut (.*);

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // image and register copy
  logic [15:0] img [STORE_W*STORE_H];
  bit          loaded [STORE_W*STORE_H];
  longint      width_reg, height_reg, sx, sy, sxx, sxy, syx, syy;

  sample_t expected_samples[$];
  int      mismatches = 0;
  int      idle_pct = 0;
  int      n_samples = 0, n_loads = 0, n_cfg = 0, n_invalid = 0;

  // expected sample for a request; unsafe when it would read an unloaded pixel
  function automatic void predict_sample(input logic [1:0] kind,
                                         input logic [OCOL_W-1:0] c, r,
                                         output sample_t s, output bit unsafe);
    longint x, y, xi, yi, fx, fy, w, h;
    longint unsigned p00, p10, p01, p11, top, bot, sum;
    x = sx + longint'(c) * sxx + longint'(r) * sxy;
    y = sy + longint'(c) * syx + longint'(r) * syy;
    w = (width_reg > STORE_W) ? STORE_W : width_reg;
    h = (height_reg > STORE_H) ? STORE_H : height_reg;
    s.value = '0;
    s.ok = 1'b0;
    s.col = c;
    s.row = r;
    unsafe = 1'b0;
    if (kind == REQ_NEAREST) begin
      xi = (x + 32768) >>> 16;
      yi = (y + 32768) >>> 16;
      if (xi >= 0 && xi < w && yi >= 0 && yi < h) begin
        s.ok = 1'b1;
        s.value = img[yi*STORE_W + xi];
        unsafe = !loaded[yi*STORE_W + xi];
      end
    end else begin
      xi = x >>> 16;
      yi = y >>> 16;
      fx = x - (xi <<< 16);
      fy = y - (yi <<< 16);
      // snap points just short of the near edge or just past the far edge
      if (xi == -1 && 65536 - fx < EDGE_TOL) begin
        xi = 0; fx = 0;
      end else if (xi == w - 1 && fx < EDGE_TOL) begin
        xi = w - 2; fx = 65536;
      end
      if (yi == -1 && 65536 - fy < EDGE_TOL) begin
        yi = 0; fy = 0;
      end else if (yi == h - 1 && fy < EDGE_TOL) begin
        yi = h - 2; fy = 65536;
      end
      if (xi >= 0 && xi < w - 1 && yi >= 0 && yi < h - 1) begin
        p00 = img[yi*STORE_W + xi];
        p10 = img[yi*STORE_W + xi + 1];
        p01 = img[(yi+1)*STORE_W + xi];
        p11 = img[(yi+1)*STORE_W + xi + 1];
        unsafe = !(loaded[yi*STORE_W + xi] && loaded[yi*STORE_W + xi + 1] &&
                   loaded[(yi+1)*STORE_W + xi] && loaded[(yi+1)*STORE_W + xi + 1]);
        top = p00 * (65536 - fx) + p10 * fx;
        bot = p01 * (65536 - fx) + p11 * fx;
        sum = top * (65536 - fy) + bot * fy;
        s.ok = 1'b1;
        s.value = 16'((sum + 64'h8000_0000) >> 32);
      end
    end
  endfunction

  // one item, held until taken; random idle gaps ahead of it
  task automatic send_item(input logic [1:0] kind, input logic [7:0] lc, lr,
                           input logic [15:0] lv, input logic [11:0] oc, orow);
    sample_t s;
    bit unsafe;
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    start <= 1'b1;
    in_req_type <= kind;
    in_load_col <= lc;
    in_load_row <= lr;
    in_load_value <= lv;
    in_out_col <= oc;
    in_out_row <= orow;
    @(posedge clk iff !busy);
    if (kind == REQ_LOAD) begin
      img[lr*STORE_W + lc] = lv;
      loaded[lr*STORE_W + lc] = 1'b1;
      n_loads++;
    end else if (kind == REQ_NEAREST || kind == REQ_BILINEAR) begin
      predict_sample(kind, oc, orow, s, unsafe);
      expected_samples.push_back(s);
      n_samples++;
      if (!s.ok) n_invalid++;
    end
    @(negedge clk);
  endtask

  task automatic stop_sending();
    start <= 1'b0;
  endtask

  // wait until every sample is back, then let trailing loads settle
  task automatic drain();
    stop_sending();
    while (expected_samples.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input longint v);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= v[CFG_W-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    n_cfg++;
    case (idx)
      CFG_IN_WIDTH:  width_reg = v[DIM_W-1:0];
      CFG_IN_HEIGHT: height_reg = v[DIM_W-1:0];
      CFG_START_X:   sx = longint'($signed(v[START_W-1:0]));
      CFG_START_Y:   sy = longint'($signed(v[START_W-1:0]));
      CFG_STEP_XX:   sxx = longint'($signed(v[STEP_W-1:0]));
      CFG_STEP_XY:   sxy = longint'($signed(v[STEP_W-1:0]));
      CFG_STEP_YX:   syx = longint'($signed(v[STEP_W-1:0]));
      default:       syy = longint'($signed(v[STEP_W-1:0]));
    endcase
    @(negedge clk);
  endtask

  task automatic set_transform(input longint x0, y0, xx, xy, yx, yy);
    write_reg(CFG_START_X, x0);
    write_reg(CFG_START_Y, y0);
    write_reg(CFG_STEP_XX, xx);
    write_reg(CFG_STEP_XY, xy);
    write_reg(CFG_STEP_YX, yx);
    write_reg(CFG_STEP_YY, yy);
  endtask

  task automatic load_px(input int c, r, input logic [15:0] v);
    send_item(REQ_LOAD, 8'(c), 8'(r), v, 12'($urandom), 12'($urandom));
  endtask

  task automatic sample(input logic [1:0] kind, input int c, r);
    send_item(kind, 8'($urandom), 8'($urandom), 16'($urandom), 12'(c), 12'(r));
  endtask

  // random sample that never reads an unloaded pixel
  task automatic random_sample(input bit wide);
    sample_t s;
    bit unsafe;
    logic [1:0] kind;
    logic [11:0] c, r;
    for (int t = 0; t < 20; t++) begin
      kind = $urandom_range(1) ? REQ_BILINEAR : REQ_NEAREST;
      c = wide ? 12'($urandom) : 12'($urandom_range(0, 9));
      r = wide ? 12'($urandom) : 12'($urandom_range(0, 9));
      predict_sample(kind, c, r, s, unsafe);
      if (!unsafe) begin
        sample(kind, c, r);
        return;
      end
    end
    // no safe point found: unused request code instead
    send_item(2'd3, 8'($urandom), 8'($urandom), 16'($urandom), 12'($urandom), 12'($urandom));
  endtask

  // result checking
  always @(posedge clk) begin
    sample_t e;
    if (rst_n && out_strobe) begin
      if (expected_samples.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: value %0d ok %0b col %0d row %0d",
                   out_sample_value, out_sample_valid, out_res_col, out_res_row);
      end else begin
        e = expected_samples.pop_front();
        if (out_sample_value !== e.value || out_sample_valid !== e.ok ||
            out_res_col !== e.col || out_res_row !== e.row) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp value %0d ok %0b col %0d row %0d, got %0d %0b %0d %0d",
                     e.value, e.ok, e.col, e.row, out_sample_value, out_sample_valid,
                     out_res_col, out_res_row);
        end
      end
    end
  end

  // default registers after reset: identity over the full store
  task automatic test_reset_defaults();
    load_px(0, 0, 16'h0000);
    load_px(1, 0, 16'hFFFF);
    load_px(0, 1, 16'h1234);
    load_px(1, 1, 16'hABCD);
    sample(REQ_NEAREST, 1, 0);
    sample(REQ_BILINEAR, 0, 0);
    load_px(255, 255, 16'h5A5A);
    sample(REQ_NEAREST, 255, 255);
    sample(REQ_BILINEAR, 4095, 4095);
    sample(2'd3, 0, 0);
    drain();
  endtask

  // small image, fractional points, both edge snaps, size 1 and 0
  task automatic test_edges();
    write_reg(CFG_IN_WIDTH, 3);
    write_reg(CFG_IN_HEIGHT, 3);
    set_transform(32768, 16384, 65536, 0, 0, 65536);
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++) load_px(c, r, 16'($urandom));
    sample(REQ_BILINEAR, 0, 0);
    sample(REQ_NEAREST, 0, 0);
    sample(REQ_NEAREST, 2, 2);
    sample(REQ_BILINEAR, 1, 1);
    drain();
    // just below zero and just past the far edge
    set_transform(-8, 2*65536 + 5, 65536, 0, 0, -65536);
    sample(REQ_BILINEAR, 0, 0);
    sample(REQ_BILINEAR, 2, 0);
    sample(REQ_BILINEAR, 0, 2);
    sample(REQ_NEAREST, 3, 0);
    drain();
    write_reg(CFG_IN_WIDTH, 1);
    sample(REQ_BILINEAR, 0, 0);
    sample(REQ_NEAREST, 0, 0);
    drain();
    write_reg(CFG_IN_WIDTH, 0);
    sample(REQ_NEAREST, 0, 0);
    drain();
  endtask

  // extreme register values; points land far outside
  task automatic test_reg_extremes();
    write_reg(CFG_IN_WIDTH, 511);
    write_reg(CFG_IN_HEIGHT, 511);
    set_transform(-16777216, 16777215, 8388607, -8388608, -8388608, 8388607);
    sample(REQ_NEAREST, 4095, 0);
    sample(REQ_BILINEAR, 0, 4095);
    sample(REQ_NEAREST, 4095, 4095);
    drain();
    set_transform(16777215, -16777216, -8388608, 8388607, 8388607, -8388608);
    sample(REQ_BILINEAR, 4095, 4095);
    sample(REQ_NEAREST, 1, 1);
    drain();
  endtask

  // random phases: new registers, loads, then mostly in-range samples
  task automatic test_random_phases();
    int pcts[4] = '{0, 52, 15, 52};
    longint w, h, we, he;
    int budget;
    for (int ph = 0; ph < 10; ph++) begin
      idle_pct = pcts[ph % 4];
      case ($urandom_range(5))
        0: begin w = $urandom_range(257, 511); h = $urandom_range(1, 511); end
        1: begin w = 1; h = $urandom_range(2, 6); end
        default: begin w = $urandom_range(2, 8); h = $urandom_range(2, 8); end
      endcase
      write_reg(CFG_IN_WIDTH, w);
      write_reg(CFG_IN_HEIGHT, h);
      we = (w > 8) ? 8 : w;
      he = (h > 8) ? 8 : h;
      set_transform(longint'($urandom_range(0, we*65536)) - 32768,
                    longint'($urandom_range(0, he*65536)) - 32768,
                    longint'($urandom_range(0, 131072)) - 65536,
                    longint'($urandom_range(0, 65536)) - 32768,
                    longint'($urandom_range(0, 65536)) - 32768,
                    longint'($urandom_range(0, 131072)) - 65536);
      for (int r = 0; r < he; r++)
        for (int c = 0; c < we; c++) load_px(c, r, 16'($urandom));
      budget = 25;
      for (int i = 0; i < budget; i++) begin
        case ($urandom_range(9))
          0: load_px($urandom, $urandom, 16'($urandom));
          1: random_sample(1'b1);
          2: load_px($urandom_range(0, 7), $urandom_range(0, 7), 16'($urandom));
          default: random_sample(1'b0);
        endcase
      end
      // one phase drains, sends one more sample and drains again
      if (ph == 3) begin
        drain();
        random_sample(1'b0);
      end
      drain();
    end
    idle_pct = 0;
  endtask

  initial begin
    width_reg = 256; height_reg = 256;
    sx = 0; sy = 0; sxx = 65536; sxy = 0; syx = 0; syy = 65536;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_reset_defaults();
    test_edges();
    test_reg_extremes();
    test_random_phases();
    drain();
    $display("covered %0d samples (%0d outside the source), %0d loads, %0d register writes",
             n_samples, n_invalid, n_loads, n_cfg);
    if (mismatches == 0) begin
      $display("tb passed");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("tb failed");
    end
    $finish;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("timeout");
    $display("tb failed");
    $finish;
  end

endmodule
